/* rtl/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants, types and helpers of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // default number of fraction bits on the color channels
   localparam int FRACTION_BITS_DEF = 8;

   // register stages from input to output register
   localparam int PIPE_DEPTH = 7;

   // hue wrap: bias is a multiple of 360 that makes any 16 bit hue positive
   localparam int unsigned HUE_FULL   = 360;
   localparam int unsigned HUE_BIAS   = 33120;
   localparam int unsigned HUE_RECIP  = 46603;   // floor(2^24 / 360)
   localparam int unsigned HUE_SHIFT  = 24;

   // percent to byte: floor(255 * p / 100) = (p * 255 * 5243) >> 19
   localparam int unsigned PCT_MAX    = 100;
   localparam int unsigned PCT_SCALE  = 1336965;
   localparam int unsigned PCT_SHIFT  = 19;

   // ceil(x / 255) = ((x + 254) * 65794) >> 24 for x below 2^16
   localparam int unsigned BYTE_ROUND = 254;
   localparam int unsigned BYTE_RECIP = 65794;
   localparam int unsigned BYTE_SHIFT = 24;

   // degrees per sector
   localparam int unsigned SECT_DEG   = 60;

   // sector code: channel holding max, channel ramping and its direction
   typedef enum logic [2:0] {
      SEC_R_G_UP = 3'd0,
      SEC_G_R_DN = 3'd1,
      SEC_G_B_UP = 3'd2,
      SEC_B_G_DN = 3'd3,
      SEC_B_R_UP = 3'd4,
      SEC_R_B_DN = 3'd5
   } sector_type;

   // control handed to the channel mixer
   typedef struct packed {
      sector_type  sector;
      logic [7:0]  max_lvl;
      logic [7:0]  min_lvl;
   } mix_ctl_type;

   // clamp a signed percent to 0..100
   function automatic logic [6:0] pct_clamp(input logic signed [7:0] p);
      logic [6:0] r;
      if (p < 8'sd0) begin
         r = 7'd0;
      end else if (p > $signed(8'(PCT_MAX))) begin
         r = 7'(PCT_MAX);
      end else begin
         r = p[6:0];
      end
      return r;
   endfunction

   // sectors where the ramp falls from max to min
   function automatic logic is_falling(input sector_type s);
      logic r;
      case (s)
         SEC_G_R_DN: r = 1'b1;
         SEC_B_G_DN: r = 1'b1;
         SEC_R_B_DN: r = 1'b1;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/hsv2rgb_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_req_if
// input channel of the converter: one hsv color plus alpha per item
// ----------------------------------------------------------------------------
interface hsv2rgb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] hue;
   logic signed [7:0]  saturation;
   logic signed [7:0]  brightness;
   logic [7:0]         alpha_in;

   modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
   modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

/* rtl/hsv2rgb_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_rsp_if
// result channel of the converter: one rgb color plus alpha per item
// ----------------------------------------------------------------------------
interface hsv2rgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic [7:0]  alpha_out;

   modport source (output valid, red, green, blue, alpha_out, input ready);
   modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

/* rtl/hsv2rgb_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// builds the three fixed point channels from max, min and ramp by sector
// ----------------------------------------------------------------------------
module hsv2rgb_mix #(
   parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
   input  hsv2rgb_pkg::mix_ctl_type       ctl,
   input  logic [8+FRACTION_BITS-1:0]     ramp_frac,
   output logic [15:0]                    red,
   output logic [15:0]                    green,
   output logic [15:0]                    blue
);

   localparam int LW = 8 + FRACTION_BITS;

   function automatic logic [15:0] sat16(input logic [LW-1:0] x);
      logic [LW+15:0] w;
      w = (LW+16)'(x);
      return (w > (LW+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   logic [LW-1:0] max_fx;
   logic [LW-1:0] min_fx;
   logic [15:0]   max_ch;
   logic [15:0]   min_ch;
   logic [15:0]   ramp_ch;

   // ramp never exceeds the max level, so LW bits hold the sum
   assign max_fx  = LW'(ctl.max_lvl) << FRACTION_BITS;
   assign min_fx  = LW'(ctl.min_lvl) << FRACTION_BITS;
   assign max_ch  = sat16(max_fx);
   assign min_ch  = sat16(min_fx);
   assign ramp_ch = sat16(min_fx + ramp_frac);

   always_comb begin
      case (ctl.sector)
         hsv2rgb_pkg::SEC_R_G_UP: begin
            red = max_ch;  green = ramp_ch; blue = min_ch;
         end
         hsv2rgb_pkg::SEC_G_R_DN: begin
            red = ramp_ch; green = max_ch;  blue = min_ch;
         end
         hsv2rgb_pkg::SEC_G_B_UP: begin
            red = min_ch;  green = max_ch;  blue = ramp_ch;
         end
         hsv2rgb_pkg::SEC_B_G_DN: begin
            red = min_ch;  green = ramp_ch; blue = max_ch;
         end
         hsv2rgb_pkg::SEC_B_R_UP: begin
            red = ramp_ch; green = min_ch;  blue = max_ch;
         end
         default: begin
            red = max_ch;  green = min_ch;  blue = ramp_ch;
         end
      endcase
   end

endmodule

/* rtl/hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// hsv plus alpha to rgb plus alpha, channels in fixed point on a 0..255 scale
// ----------------------------------------------------------------------------
// throughput: one item per cycle with no backpressure; each of the 7 register
//   stages takes a new item whenever it is empty or its successor moves, so
//   bubbles close up
// reset: synchronous, clears the stage valid bits only; payload is not reset
module hsv_to_rgb_converter #(
   parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_req_if.sink          req_chan,
   hsv2rgb_rsp_if.source        rsp_chan
);

   localparam int DEPTH = hsv2rgb_pkg::PIPE_DEPTH;
   localparam int LW    = 8 + FRACTION_BITS;      // channel value before saturation
   localparam int XW    = 14 + FRACTION_BITS;     // span scaled by the fraction
   localparam int K     = XW + 6;                 // reciprocal shift for / 60
   localparam int MW    = K - 5;                  // reciprocal width
   localparam logic [MW-1:0] DIV60_M = MW'(((64'd1 << K) + 64'd59) / 64'd60);

   // ------------------------------------------------------------------
   // stage valid bits and the advance chain
   // ------------------------------------------------------------------
   logic [DEPTH:1] vld_ff;
   logic [DEPTH:1] vld_in;
   logic [DEPTH:1] adv;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      adv[DEPTH] = !vld_ff[DEPTH] || rsp_chan.ready;
      for (int k = DEPTH - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in = {vld_ff[DEPTH-1:1], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= DEPTH; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_chan.ready = adv[1];

   // ------------------------------------------------------------------
   // stage 1: bias hue positive, clamp percentages
   // ------------------------------------------------------------------
   logic [16:0] s1_hue_ff,   s1_hue_in;
   logic [6:0]  s1_sat_ff,   s1_sat_in;
   logic [6:0]  s1_val_ff,   s1_val_in;
   logic [7:0]  s1_alpha_ff;

   // true sum lies in 352..65887, so modulo 2^17 arithmetic is exact
   assign s1_hue_in = {req_chan.hue[15], req_chan.hue} + 17'(hsv2rgb_pkg::HUE_BIAS);
   assign s1_sat_in = hsv2rgb_pkg::pct_clamp(req_chan.saturation);
   assign s1_val_in = hsv2rgb_pkg::pct_clamp(req_chan.brightness);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_hue_ff   <= s1_hue_in;
         s1_sat_ff   <= s1_sat_in;
         s1_val_ff   <= s1_val_in;
         s1_alpha_ff <= req_chan.alpha_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: estimate hue / 360, scale percentages to bytes
   // ------------------------------------------------------------------
   logic [32:0] hue_prod;
   logic [27:0] sat_prod;
   logic [27:0] val_prod;
   logic [7:0]  s2_hq_ff;
   logic [16:0] s2_hue_ff;
   logic [7:0]  s2_sat_ff;
   logic [7:0]  s2_max_ff;
   logic [7:0]  s2_alpha_ff;

   // quotient estimate is exact or one low
   assign hue_prod = 33'(s1_hue_ff) * 33'(hsv2rgb_pkg::HUE_RECIP);
   assign sat_prod = 28'(s1_sat_ff) * 28'(hsv2rgb_pkg::PCT_SCALE);
   assign val_prod = 28'(s1_val_ff) * 28'(hsv2rgb_pkg::PCT_SCALE);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_hq_ff    <= hue_prod[hsv2rgb_pkg::HUE_SHIFT +: 8];
         s2_hue_ff   <= s1_hue_ff;
         s2_sat_ff   <= sat_prod[hsv2rgb_pkg::PCT_SHIFT +: 8];
         s2_max_ff   <= val_prod[hsv2rgb_pkg::PCT_SHIFT +: 8];
         s2_alpha_ff <= s1_alpha_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: hue remainder with one correction, s * max product
   // ------------------------------------------------------------------
   logic [16:0] hq_mul;
   logic [16:0] hue_rem;
   logic [8:0]  s3_hue_ff,   s3_hue_in;
   logic [15:0] s3_prod_ff,  s3_prod_in;
   logic [7:0]  s3_max_ff;
   logic [7:0]  s3_alpha_ff;

   assign hq_mul     = 17'(s2_hq_ff) * 17'(hsv2rgb_pkg::HUE_FULL);
   assign hue_rem    = s2_hue_ff - hq_mul;           // below 720
   assign s3_hue_in  = (hue_rem >= 17'(hsv2rgb_pkg::HUE_FULL))
                     ? 9'(hue_rem - 17'(hsv2rgb_pkg::HUE_FULL)) : 9'(hue_rem);
   assign s3_prod_in = 16'(s2_sat_ff) * 16'(s2_max_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_hue_ff   <= s3_hue_in;
         s3_prod_ff  <= s3_prod_in;
         s3_max_ff   <= s2_max_ff;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: min = max - ceil(s * max / 255), sector and offset
   // ------------------------------------------------------------------
   logic [16:0] ceil_num;
   logic [33:0] ceil_prod;
   logic [7:0]  ceil_q;
   logic [8:0]  sect_base;
   hsv2rgb_pkg::sector_type s4_sector_ff, s4_sector_in;
   logic [5:0]  s4_off_ff,   s4_off_in;
   logic [7:0]  s4_max_ff;
   logic [7:0]  s4_min_ff,   s4_min_in;
   logic [7:0]  s4_alpha_ff;

   assign ceil_num  = 17'(s3_prod_ff) + 17'(hsv2rgb_pkg::BYTE_ROUND);
   assign ceil_prod = 34'(ceil_num) * 34'(hsv2rgb_pkg::BYTE_RECIP);
   assign ceil_q    = ceil_prod[hsv2rgb_pkg::BYTE_SHIFT +: 8];
   assign s4_min_in = s3_max_ff - ceil_q;

   // exact multiples of 60 fall in the upper sector with zero offset
   always_comb begin
      if (s3_hue_ff >= 9'(5 * hsv2rgb_pkg::SECT_DEG)) begin
         s4_sector_in = hsv2rgb_pkg::SEC_R_B_DN;
         sect_base    = 9'(5 * hsv2rgb_pkg::SECT_DEG);
      end else if (s3_hue_ff >= 9'(4 * hsv2rgb_pkg::SECT_DEG)) begin
         s4_sector_in = hsv2rgb_pkg::SEC_B_R_UP;
         sect_base    = 9'(4 * hsv2rgb_pkg::SECT_DEG);
      end else if (s3_hue_ff >= 9'(3 * hsv2rgb_pkg::SECT_DEG)) begin
         s4_sector_in = hsv2rgb_pkg::SEC_B_G_DN;
         sect_base    = 9'(3 * hsv2rgb_pkg::SECT_DEG);
      end else if (s3_hue_ff >= 9'(2 * hsv2rgb_pkg::SECT_DEG)) begin
         s4_sector_in = hsv2rgb_pkg::SEC_G_B_UP;
         sect_base    = 9'(2 * hsv2rgb_pkg::SECT_DEG);
      end else if (s3_hue_ff >= 9'(hsv2rgb_pkg::SECT_DEG)) begin
         s4_sector_in = hsv2rgb_pkg::SEC_G_R_DN;
         sect_base    = 9'(hsv2rgb_pkg::SECT_DEG);
      end else begin
         s4_sector_in = hsv2rgb_pkg::SEC_R_G_UP;
         sect_base    = 9'd0;
      end
   end

   assign s4_off_in = 6'(s3_hue_ff - sect_base);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_sector_ff <= s4_sector_in;
         s4_off_ff    <= s4_off_in;
         s4_max_ff    <= s3_max_ff;
         s4_min_ff    <= s4_min_in;
         s4_alpha_ff  <= s3_alpha_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: ramp span = offset * (max - min), offset mirrored when falling
   // ------------------------------------------------------------------
   logic [5:0]  ramp_off;
   logic [7:0]  lvl_diff;
   logic [13:0] s5_span_ff,  s5_span_in;
   hsv2rgb_pkg::sector_type s5_sector_ff;
   logic [7:0]  s5_max_ff;
   logic [7:0]  s5_min_ff;
   logic [7:0]  s5_alpha_ff;

   assign ramp_off   = hsv2rgb_pkg::is_falling(s4_sector_ff)
                     ? 6'(hsv2rgb_pkg::SECT_DEG) - s4_off_ff : s4_off_ff;
   assign lvl_diff   = s4_max_ff - s4_min_ff;
   assign s5_span_in = 14'(ramp_off) * 14'(lvl_diff);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_span_ff   <= s5_span_in;
         s5_sector_ff <= s4_sector_ff;
         s5_max_ff    <= s4_max_ff;
         s5_min_ff    <= s4_min_ff;
         s5_alpha_ff  <= s4_alpha_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: floor((span << fraction) / 60) by reciprocal
   // ------------------------------------------------------------------
   logic [XW-1:0]      span_fx;
   logic [XW+MW-1:0]   div_prod;
   logic [LW-1:0]      s6_frac_ff;
   hsv2rgb_pkg::mix_ctl_type s6_ctl_ff;
   logic [7:0]         s6_alpha_ff;

   // reciprocal error stays below one part in 60 of the span range
   assign span_fx  = XW'(s5_span_ff) << FRACTION_BITS;
   assign div_prod = (XW+MW)'(span_fx) * (XW+MW)'(DIV60_M);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_frac_ff        <= div_prod[K +: LW];
         s6_ctl_ff.sector  <= s5_sector_ff;
         s6_ctl_ff.max_lvl <= s5_max_ff;
         s6_ctl_ff.min_lvl <= s5_min_ff;
         s6_alpha_ff       <= s5_alpha_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: place max, min and ramp on the channels, output register
   // ------------------------------------------------------------------
   logic [15:0] mix_red;
   logic [15:0] mix_green;
   logic [15:0] mix_blue;
   logic [15:0] s7_red_ff;
   logic [15:0] s7_green_ff;
   logic [15:0] s7_blue_ff;
   logic [7:0]  s7_alpha_ff;

   hsv2rgb_mix #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mix (
      .ctl       (s6_ctl_ff),
      .ramp_frac (s6_frac_ff),
      .red       (mix_red),
      .green     (mix_green),
      .blue      (mix_blue)
   );

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_red_ff   <= mix_red;
         s7_green_ff <= mix_green;
         s7_blue_ff  <= mix_blue;
         s7_alpha_ff <= s6_alpha_ff;
      end
   end

   assign rsp_chan.valid     = vld_ff[DEPTH];
   assign rsp_chan.red       = s7_red_ff;
   assign rsp_chan.green     = s7_green_ff;
   assign rsp_chan.blue      = s7_blue_ff;
   assign rsp_chan.alpha_out = s7_alpha_ff;

endmodule

/* rtl/hsv2rgb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port level assertions on the converter, attached by bind
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] red,
   input logic [15:0] green,
   input logic [15:0] blue,
   input logic [7:0]  alpha_out
);

   // reset empties the pipe and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

   // input only stalls when a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // with the output open, an accepted item passes every stage and shows up at the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item did not arrive at the output in time");

   // a held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(alpha_out))
      else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red       (rsp_chan.red),
   .green     (rsp_chan.green),
   .blue      (rsp_chan.blue),
   .alpha_out (rsp_chan.alpha_out)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the hsv to rgb converter item by item against a behavioral color
// predictor: hue wrap, sector edges and percent clamping first, then random
// colors under random stalls on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;

   // fraction bits of the instance under test and its pipeline depth
   localparam int FRAC    = hsv2rgb_pkg::FRACTION_BITS_DEF;
   localparam int LATENCY = hsv2rgb_pkg::PIPE_DEPTH;

   // one input color and one output color, at the port widths
   typedef struct packed {
      logic signed [15:0] hue;
      logic signed [7:0]  saturation;
      logic signed [7:0]  brightness;
      logic [7:0]         alpha;
   } hsv_color_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [7:0]  alpha;
   } rgb_color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsv2rgb_req_if req_chan ();
   hsv2rgb_rsp_if rsp_chan ();

   hsv_to_rgb_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // colors predicted for accepted items, oldest first
   rgb_color_type expected_colors[$];

   int error_count    = 0;
   int send_idle_pct  = 0;   // chance in percent that the sender idles a cycle
   int recv_idle_pct  = 0;   // chance in percent that the receiver stalls a cycle
   int hold_request   = 0;   // long receiver hold-off asked by a test, in cycles
   int hold_left      = 0;   // cycles of that hold-off still to run

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // color predictor
   // ------------------------------------------------------------------------

   // clamp a signed percent to 0..100 and scale to 0..255, truncated
   function automatic int unsigned percent_to_level(input logic signed [7:0] p);
      int q;
      q = p;
      if (q < 0) begin
         q = 0;
      end
      if (q > 100) begin
         q = 100;
      end
      return (255 * q) / 100;
   endfunction

   // flat channel level in fixed point, saturating at 16 bits
   function automatic logic [15:0] fixed_level(input int unsigned x);
      longint unsigned v;
      v = longint'(x) << FRAC;
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   // channel ramping from min toward max over the 60 degrees of a sector
   function automatic logic [15:0] fixed_ramp(input int unsigned d, input int unsigned mx,
                                               input int unsigned mn);
      longint unsigned span;
      longint unsigned v;
      span = (longint'(d) * longint'(mx - mn)) << FRAC;
      v    = (longint'(mn) << FRAC) + span / 60;
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic rgb_color_type predict_rgb(input hsv_color_type c);
      int                      h;
      int unsigned             sat_lvl;
      int unsigned             max_lvl;
      int unsigned             min_lvl;
      int unsigned             d;
      hsv2rgb_pkg::sector_type sector;
      rgb_color_type           o;
      // wrap hue into 0..359, the remainder of a negative hue is negative
      h = int'(c.hue) % 360;
      if (h < 0) begin
         h += 360;
      end
      sat_lvl = percent_to_level(c.saturation);
      max_lvl = percent_to_level(c.brightness);
      // exact ceil(s * max / 255) keeps the minimum free of rounding noise
      min_lvl = max_lvl - (sat_lvl * max_lvl + 254) / 255;
      sector  = hsv2rgb_pkg::sector_type'(3'(h / 60));
      d       = h % 60;
      case (sector)
         hsv2rgb_pkg::SEC_R_G_UP: begin
            o.red   = fixed_level(max_lvl);
            o.green = fixed_ramp(d, max_lvl, min_lvl);
            o.blue  = fixed_level(min_lvl);
         end
         hsv2rgb_pkg::SEC_G_R_DN: begin
            o.red   = fixed_ramp(60 - d, max_lvl, min_lvl);
            o.green = fixed_level(max_lvl);
            o.blue  = fixed_level(min_lvl);
         end
         hsv2rgb_pkg::SEC_G_B_UP: begin
            o.red   = fixed_level(min_lvl);
            o.green = fixed_level(max_lvl);
            o.blue  = fixed_ramp(d, max_lvl, min_lvl);
         end
         hsv2rgb_pkg::SEC_B_G_DN: begin
            o.red   = fixed_level(min_lvl);
            o.green = fixed_ramp(60 - d, max_lvl, min_lvl);
            o.blue  = fixed_level(max_lvl);
         end
         hsv2rgb_pkg::SEC_B_R_UP: begin
            o.red   = fixed_ramp(d, max_lvl, min_lvl);
            o.green = fixed_level(min_lvl);
            o.blue  = fixed_level(max_lvl);
         end
         default: begin
            o.red   = fixed_level(max_lvl);
            o.green = fixed_level(min_lvl);
            o.blue  = fixed_ramp(60 - d, max_lvl, min_lvl);
         end
      endcase
      o.alpha = c.alpha;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // mismatch reporting
   // ------------------------------------------------------------------------
   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // result side: ready with random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left     = hold_request;
         hold_request  = 0;
      end
      if (hold_left > 0) begin
         hold_left       = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // outputs are sampled mid-cycle, an item seen here is taken at the next edge
   always @(negedge clock) begin
      rgb_color_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_colors.size() == 0) begin
            report_error($sformatf("unexpected item r=%h g=%h b=%h a=%h", rsp_chan.red,
                                   rsp_chan.green, rsp_chan.blue, rsp_chan.alpha_out));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_chan.red !== want.red) begin
               report_error($sformatf("red %h, expected %h", rsp_chan.red, want.red));
            end
            if (rsp_chan.green !== want.green) begin
               report_error($sformatf("green %h, expected %h", rsp_chan.green, want.green));
            end
            if (rsp_chan.blue !== want.blue) begin
               report_error($sformatf("blue %h, expected %h", rsp_chan.blue, want.blue));
            end
            if (rsp_chan.alpha_out !== want.alpha) begin
               report_error($sformatf("alpha %h, expected %h", rsp_chan.alpha_out,
                                      want.alpha));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------------

   // offer one item; called and returning just after a rising edge
   task automatic send_color(input hsv_color_type c);
      bit taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.hue        <= c.hue;
      req_chan.saturation <= c.saturation;
      req_chan.brightness <= c.brightness;
      req_chan.alpha_in   <= c.alpha;
      // ready is stable mid-cycle, so the decision is free of edge races
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_chan.ready;
      end
      expected_colors.push_back(predict_rgb(c));
      @(posedge clock);
   endtask

   task automatic send_hsv(input int h, input int s, input int v, input int a);
      hsv_color_type c;
      c.hue        = 16'(h);
      c.saturation = 8'(s);
      c.brightness = 8'(v);
      c.alpha      = 8'(a);
      send_color(c);
   endtask

   // sender pauses until every predicted color has come out
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (expected_colors.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // mostly in-range percents and any hue, some raw bytes for the clamps
   function automatic hsv_color_type random_color();
      hsv_color_type c;
      if ($urandom_range(3) != 0) begin
         c.hue = 16'($urandom);
      end else begin
         c.hue = 16'(int'($urandom_range(720)) - 360);
      end
      c.saturation = ($urandom_range(3) != 0) ? 8'($urandom_range(100)) : 8'($urandom);
      c.brightness = ($urandom_range(3) != 0) ? 8'($urandom_range(100)) : 8'($urandom);
      c.alpha      = 8'($urandom);
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // negative, large and exact multiples of 360 all wrap into 0..359
   task automatic test_hue_wrap();
      send_hsv(-32768, 100, 100, 8'h00);
      send_hsv(32767, 100, 100, 8'hFF);
      send_hsv(360, 100, 100, 8'h5A);
      send_hsv(-1, 80, 90, 8'hA5);
      send_hsv(-360, 100, 100, 8'h01);
      send_hsv(720, 70, 60, 8'h80);
   endtask

   // each sector entered at its lower edge, plus the top of the last one
   task automatic test_sector_edges();
      send_hsv(0, 100, 100, 8'h11);
      send_hsv(60, 100, 100, 8'h22);
      send_hsv(120, 75, 100, 8'h33);
      send_hsv(180, 100, 50, 8'h44);
      send_hsv(240, 40, 100, 8'h55);
      send_hsv(300, 100, 100, 8'h66);
      send_hsv(359, 100, 100, 8'h77);
   endtask

   // percents below 0 and above 100, and the ends of the legal range
   task automatic test_percent_clamp();
      send_hsv(45, -128, -128, 8'hFF);
      send_hsv(200, 127, 127, 8'h00);
      send_hsv(100, 0, 100, 8'hC3);
      send_hsv(260, 100, 0, 8'h3C);
      send_hsv(330, 101, -1, 8'h7F);
      send_hsv(15, 50, 37, 8'hFE);
   endtask

   task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         send_color(random_color());
      end
      wait_results_drained();
   endtask

   // output held off long enough that the pipeline fills and stalls the input
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      hold_request = 4 * LATENCY + 20;
      @(posedge clock);
      repeat (40) begin
         send_color(random_color());
      end
      wait_results_drained();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.hue        = '0;
      req_chan.saturation = '0;
      req_chan.brightness = '0;
      req_chan.alpha_in   = '0;
      rsp_chan.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hue_wrap();
      test_sector_edges();
      test_percent_clamp();
      wait_results_drained();

      test_random_stream(165, 34, 68);
      test_random_stream(165, 68, 34);
      test_random_stream(130, 0, 0);
      test_output_stall();

      if (expected_colors.size() != 0) begin
         report_error($sformatf("%0d items never came out", expected_colors.size()));
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout, %0d items outstanding", expected_colors.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_req_if.sv
rtl/hsv2rgb_rsp_if.sv
rtl/hsv2rgb_mix.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsv2rgb_checker.sv
verif/testbench.sv
